// ===== rtl/hnf_pkg.sv =====
// Package for the haversine nearest/farthest tracker.
// Constants, job and control types, arctangent table. No dependencies.
`default_nettype none
package hnf_pkg;
    localparam int MAX_SITES    = 1024;
    localparam int CNT_W        = $clog2(MAX_SITES);
    localparam int NUM_W        = 10;
    localparam int DIST_W       = 22;
    localparam int CORDIC_STEPS = 24;
    localparam int IDX_W        = 5;
    localparam int CW           = 34;

    localparam logic [31:0] PI30        = 32'd3373259426;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam logic [31:0] HALF_PI30   = 32'h6487ED51;
    localparam logic [30:0] ONE30       = 31'h4000_0000;
    localparam logic [DIST_W-1:0] DIST_MAX = 22'd2573400;

    typedef struct packed {
        logic [27:0] dlat;
        logic [27:0] dlon;
        logic [27:0] alat1;
        logic [27:0] alat2;
        logic        last;
    } t_job;

    typedef struct packed {
        logic start;
        logic vector_mode;
    } t_cordic_ctl;

    function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/haversine_nearest_farthest.sv =====
// Top level: APB configuration registers, front end, job queue, back end.
// Depends on hnf_pkg, hnf_front, hnf_fifo, hnf_back.
//
// From the queue to its result each site passes through four
// angle passes, each a reciprocal multiply with up to two correction steps
// plus a 24-step CORDIC rotation, four rounded products, two 31-step square
// roots and one CORDIC vectoring pass, all run by the back-end sequencer on
// one multiplier and one CORDIC unit.
// The front end and a two-entry queue take sites while the back end works,
// and a finished result waits in the output register without blocking the
// next site. No clearing pass follows reset.
`default_nettype none
module haversine_nearest_farthest (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_site_valid,
    output logic                              o_site_stall,
    input  wire logic signed [27:0]           i_site_latitude,
    input  wire logic signed [28:0]           i_site_longitude,
    input  wire logic                         i_final_site,
    output logic                              o_res_valid,
    input  wire logic                         i_res_stall,
    output logic [hnf_pkg::NUM_W-1:0]         o_site_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_site_distance,
    output logic                              o_set_done,
    output logic [hnf_pkg::NUM_W-1:0]         o_nearest_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_nearest_distance,
    output logic [hnf_pkg::NUM_W-1:0]         o_farthest_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_farthest_distance,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import hnf_pkg::*;

    localparam logic [1:0] REG_ORG_LAT = 2'd0;
    localparam logic [1:0] REG_ORG_LON = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    logic signed [27:0] r_org_lat;
    logic signed [28:0] r_org_lon;
    logic [12:0]        r_radius;
    t_job               fjob, qjob;
    logic               qfull, qnempty, pop, push;

    assign pready       = 1'b1;
    assign o_site_stall = qfull;
    assign push         = i_site_valid && !qfull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_lat <= '0;
            r_org_lon <= '0;
            r_radius  <= 13'd6371;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ORG_LAT: r_org_lat <= pwdata[27:0];
                REG_ORG_LON: r_org_lon <= pwdata[28:0];
                REG_RADIUS:  r_radius  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ORG_LAT: prdata = {4'b0, r_org_lat};
            REG_ORG_LON: prdata = {3'b0, r_org_lon};
            REG_RADIUS:  prdata = {19'b0, r_radius};
            default:     prdata = '0;
        endcase
    end

    hnf_front u_front (
        .i_site_latitude   (i_site_latitude),
        .i_site_longitude  (i_site_longitude),
        .i_final_site      (i_final_site),
        .i_origin_latitude (r_org_lat),
        .i_origin_longitude(r_org_lon),
        .o_job             (fjob)
    );

    hnf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fjob),
        .o_full  (qfull),
        .i_pop   (pop),
        .o_nempty(qnempty),
        .o_job   (qjob)
    );

    hnf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_valid        (qnempty),
        .i_job              (qjob),
        .o_pop              (pop),
        .i_radius           (r_radius),
        .i_res_stall        (i_res_stall),
        .o_res_valid        (o_res_valid),
        .o_site_number      (o_site_number),
        .o_site_distance    (o_site_distance),
        .o_set_done         (o_set_done),
        .o_nearest_number   (o_nearest_number),
        .o_nearest_distance (o_nearest_distance),
        .o_farthest_number  (o_farthest_number),
        .o_farthest_distance(o_farthest_distance)
    );
endmodule
`default_nettype wire

// ===== rtl/hnf_front.sv =====
// Front end: clamps coordinates and forms the angle differences of one site.
// Depends on hnf_pkg.
`default_nettype none
module hnf_front (
    input  wire logic signed [27:0] i_site_latitude,
    input  wire logic signed [28:0] i_site_longitude,
    input  wire logic               i_final_site,
    input  wire logic signed [27:0] i_origin_latitude,
    input  wire logic signed [28:0] i_origin_longitude,
    output hnf_pkg::t_job           o_job
);
    import hnf_pkg::*;

    localparam logic signed [29:0] LAT_LIM = 30'sd90000000;
    localparam logic signed [29:0] LON_LIM = 30'sd180000000;
    localparam logic [28:0] LON_TURN = 29'd360000000;
    localparam logic [28:0] LON_HALF = 29'd180000000;

    function automatic logic signed [29:0] clamp_lim(input logic signed [29:0] v,
                                                     input logic signed [29:0] lim);
        logic signed [29:0] r;
        if (v > lim) r = lim;
        else if (v < -lim) r = -lim;
        else r = v;
        return r;
    endfunction

    logic signed [29:0] lat1, lat2, lon1, lon2, dla, dlo;
    logic [28:0] ulo;

    always_comb begin
        lat1 = clamp_lim(30'(i_origin_latitude), LAT_LIM);
        lat2 = clamp_lim(30'(i_site_latitude), LAT_LIM);
        lon1 = clamp_lim(30'(i_origin_longitude), LON_LIM);
        lon2 = clamp_lim(30'(i_site_longitude), LON_LIM);
        dla  = lat1 - lat2;
        dlo  = lon1 - lon2;
        ulo  = 29'(dlo < 0 ? -dlo : dlo);
        if (ulo > LON_HALF) ulo = LON_TURN - ulo;
        o_job.dlat  = 28'(dla < 0 ? -dla : dla);
        o_job.dlon  = 28'(ulo);
        o_job.alat1 = 28'(lat1 < 0 ? -lat1 : lat1);
        o_job.alat2 = 28'(lat2 < 0 ? -lat2 : lat2);
        o_job.last  = i_final_site;
    end
endmodule
`default_nettype wire

// ===== rtl/hnf_fifo.sv =====
// Two-entry job queue between front and back.
// Depends on hnf_pkg.
`default_nettype none
module hnf_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  hnf_pkg::t_job      i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_nempty,
    output hnf_pkg::t_job      o_job
);
    import hnf_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hnf_cordic.sv =====
// Shared iterative CORDIC unit, rotation and vectoring, one step per cycle.
// Depends on hnf_pkg.
`default_nettype none
module hnf_cordic (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  hnf_pkg::t_cordic_ctl            i_ctl,
    input  wire logic signed [hnf_pkg::CW-1:0] i_x,
    input  wire logic signed [hnf_pkg::CW-1:0] i_y,
    input  wire logic signed [hnf_pkg::CW-1:0] i_z,
    output logic                            o_done,
    output logic signed [hnf_pkg::CW-1:0]   o_x,
    output logic signed [hnf_pkg::CW-1:0]   o_y,
    output logic signed [hnf_pkg::CW-1:0]   o_z
);
    import hnf_pkg::*;

    logic signed [CW-1:0] r_x, r_y, r_z, dx, dy, at;
    logic [IDX_W-1:0]     r_i;
    logic                 r_busy, r_vec, r_done;

    assign o_done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = signed'(CW'(atan_q30(r_i)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_vec  <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_vec  <= i_ctl.vector_mode;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_vec) begin
                    if (r_y > 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end else if (r_y < 0) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end
                end else if (!r_z[CW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                if (r_i == IDX_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hnf_back.sv =====
// Back end: sequencer for angle division, CORDIC passes, products, square
// roots, distance and nearest/farthest tracking. Depends on hnf_pkg, hnf_cordic.
`default_nettype none
module hnf_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  hnf_pkg::t_job                     i_job,
    output logic                              o_pop,
    input  wire logic [12:0]                  i_radius,
    input  wire logic                         i_res_stall,
    output logic                              o_res_valid,
    output logic [hnf_pkg::NUM_W-1:0]         o_site_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_site_distance,
    output logic                              o_set_done,
    output logic [hnf_pkg::NUM_W-1:0]         o_nearest_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_nearest_distance,
    output logic [hnf_pkg::NUM_W-1:0]         o_farthest_number,
    output logic [hnf_pkg::DIST_W-1:0]        o_farthest_distance
);
    import hnf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIVI, S_DIV, S_DFIX, S_ROT_GO, S_ROT_WAIT, S_PMUL, S_PRND,
        S_SQRT, S_VEC_GO, S_VEC_WAIT, S_DMUL, S_SAT, S_OUT
    } t_state;

    localparam logic [28:0] DIV_HALF = 29'd360000000;
    localparam logic [63:0] ADD_HALF = 64'd180000000;
    localparam logic [63:0] RND30    = 64'h2000_0000;
    localparam logic [31:0] RECIP    = 32'((64'd1 << 60) / 64'd360000000);

    function automatic logic [30:0] clamp_unit(input logic signed [CW-1:0] v,
                                               input logic [30:0] hi);
        logic [30:0] r;
        if (v < 0) r = '0;
        else if (v > signed'(CW'(hi))) r = hi;
        else r = 31'(v);
        return r;
    endfunction

    t_state          r_state;
    t_job            r_job;
    logic [1:0]      r_k, r_ps;
    logic [63:0]     r_prod;
    logic [59:0]     r_num;
    logic [31:0]     r_rem, r_quo;
    logic [5:0]      r_cnt;
    logic [30:0]     r_slat, r_slon, r_c1, r_c2, r_p1, r_p2, r_p3, r_a, r_sa, r_root;
    logic [61:0]     r_sv;
    logic [31:0]     r_srem, r_ang;
    logic            r_second;
    logic [DIST_W-1:0] r_dist;

    logic [CNT_W-1:0]  r_count, r_near_i, r_far_i;
    logic [DIST_W-1:0] r_near_d, r_far_d;

    logic [31:0]     ma, mb;
    logic [63:0]     mprod, n_round;
    logic [27:0]     dsel;
    logic [33:0]     st, strial;
    logic [31:0]     asum;
    logic [19:0]     rad100;
    logic [23:0]     dval;
    logic            near_upd, far_upd;

    t_cordic_ctl          cctl;
    logic signed [CW-1:0] cx0, cy0, cz0, cx, cy, cz;
    logic                 cdone;

    hnf_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (cctl),
        .i_x    (cx0),
        .i_y    (cy0),
        .i_z    (cz0),
        .o_done (cdone),
        .o_x    (cx),
        .o_y    (cy),
        .o_z    (cz)
    );

    always_comb begin
        // full angle of d is the half angle of 2d
        case (r_k)
            2'd0:    dsel = r_job.dlat;
            2'd1:    dsel = r_job.dlon;
            2'd2:    dsel = {r_job.alat1[26:0], 1'b0};
            default: dsel = {r_job.alat2[26:0], 1'b0};
        endcase
        rad100 = {1'b0, i_radius, 6'b0} + {2'b0, i_radius, 5'b0} + {5'b0, i_radius, 2'b0};

        ma = {4'b0, dsel};
        mb = PI30;
        if (r_state == S_DIVI) begin
            ma = r_prod[59:28];
            mb = RECIP;
        end else if (r_state == S_DIV) begin
            ma = r_prod[63:32];
            mb = {3'b0, DIV_HALF};
        end else if (r_state == S_PMUL) begin
            case (r_ps)
                2'd0:    begin ma = {1'b0, r_slat}; mb = {1'b0, r_slat}; end
                2'd1:    begin ma = {1'b0, r_c1};   mb = {1'b0, r_c2};   end
                2'd2:    begin ma = {1'b0, r_slon}; mb = {1'b0, r_slon}; end
                default: begin ma = {1'b0, r_p2};   mb = {1'b0, r_p3};   end
            endcase
        end else if (r_state == S_DMUL) begin
            ma   = {12'b0, rad100};
            mb   = r_ang;
        end
        mprod = ma * mb;

        n_round = r_prod + RND30;
        asum    = {1'b0, r_p1} + {1'b0, n_round[60:30]};
        st      = {r_srem, r_sv[61:60]};
        strial  = {1'b0, r_root, 2'b01};
        dval    = n_round[53:30];

        cctl.start       = (r_state == S_ROT_GO) || (r_state == S_VEC_GO);
        cctl.vector_mode = (r_state == S_VEC_GO);
        cx0 = (r_state == S_VEC_GO) ? signed'(CW'(r_root)) : signed'(CW'(CORDIC_GAIN));
        cy0 = (r_state == S_VEC_GO) ? signed'(CW'(r_sa)) : '0;
        cz0 = (r_state == S_VEC_GO) ? '0 : signed'(CW'(r_quo));

        near_upd = r_dist < r_near_d;
        far_upd  = r_dist >= r_far_d;
        o_pop    = (r_state == S_IDLE) && i_job_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_res_valid <= 1'b0;
            r_count     <= '0;
            r_near_d    <= '1;
            r_near_i    <= '0;
            r_far_d     <= '0;
            r_far_i     <= '0;
        end else begin
            if (o_res_valid && !i_res_stall) o_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mprod + ADD_HALF;
                    r_state <= S_DIVI;
                end
                S_DIVI: begin
                    r_num   <= r_prod[59:0];
                    r_prod  <= mprod;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo   <= r_prod[63:32];
                    r_rem   <= 32'({4'b0, r_num} - mprod);
                    r_state <= S_DFIX;
                end
                S_DFIX: begin
                    if (r_rem >= {3'b0, DIV_HALF}) begin
                        r_rem <= r_rem - {3'b0, DIV_HALF};
                        r_quo <= r_quo + 1'b1;
                    end else begin
                        r_state <= S_ROT_GO;
                    end
                end
                S_ROT_GO: r_state <= S_ROT_WAIT;
                S_ROT_WAIT: begin
                    if (cdone) begin
                        case (r_k)
                            2'd0:    r_slat <= clamp_unit(cy, ONE30);
                            2'd1:    r_slon <= clamp_unit(cy, ONE30);
                            2'd2:    r_c1   <= clamp_unit(cx, ONE30);
                            default: r_c2   <= clamp_unit(cx, ONE30);
                        endcase
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_ps    <= 2'd0;
                            r_state <= S_PMUL;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_PMUL: begin
                    r_prod  <= mprod;
                    r_state <= S_PRND;
                end
                S_PRND: begin
                    r_ps    <= r_ps + 1'b1;
                    r_state <= S_PMUL;
                    case (r_ps)
                        2'd0:    r_p1 <= n_round[60:30];
                        2'd1:    r_p2 <= n_round[60:30];
                        2'd2:    r_p3 <= n_round[60:30];
                        default: begin
                            r_a      <= (asum > {1'b0, ONE30}) ? ONE30 : 31'(asum);
                            r_sv     <= {1'b0, ((asum > {1'b0, ONE30}) ? ONE30 : 31'(asum)),
                                         30'b0};
                            r_srem   <= '0;
                            r_root   <= '0;
                            r_cnt    <= '0;
                            r_second <= 1'b0;
                            r_state  <= S_SQRT;
                        end
                    endcase
                end
                S_SQRT: begin
                    if (st >= strial) begin
                        r_srem <= 32'(st - strial);
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_srem <= 32'(st);
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    r_sv  <= {r_sv[59:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd30) begin
                        if (!r_second) begin
                            r_sa     <= (st >= strial) ? {r_root[29:0], 1'b1}
                                                       : {r_root[29:0], 1'b0};
                            r_second <= 1'b1;
                            r_sv     <= {1'b0, ONE30 - r_a, 30'b0};
                            r_srem   <= '0;
                            r_root   <= '0;
                            r_cnt    <= '0;
                        end else begin
                            r_state <= S_VEC_GO;
                        end
                    end
                end
                S_VEC_GO: begin
                    r_quo   <= '0;
                    r_state <= S_VEC_WAIT;
                end
                S_VEC_WAIT: begin
                    if (cdone) begin
                        r_ang   <= {clamp_unit(cz, HALF_PI30[30:0]), 1'b0};
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    r_prod  <= mprod;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_dist  <= (dval > {2'b0, DIST_MAX}) ? DIST_MAX : DIST_W'(dval);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_res_valid || !i_res_stall) begin
                        o_res_valid         <= 1'b1;
                        o_site_number       <= NUM_W'(r_count);
                        o_site_distance     <= r_dist;
                        o_set_done          <= r_job.last;
                        o_nearest_number    <= NUM_W'(near_upd ? r_count : r_near_i);
                        o_nearest_distance  <= near_upd ? r_dist : r_near_d;
                        o_farthest_number   <= NUM_W'(far_upd ? r_count : r_far_i);
                        o_farthest_distance <= far_upd ? r_dist : r_far_d;
                        if (r_job.last) begin
                            r_count  <= '0;
                            r_near_d <= '1;
                            r_near_i <= '0;
                            r_far_d  <= '0;
                            r_far_i  <= '0;
                        end else begin
                            if (near_upd) begin
                                r_near_d <= r_dist;
                                r_near_i <= r_count;
                            end
                            if (far_upd) begin
                                r_far_d <= r_dist;
                                r_far_i <= r_count;
                            end
                            r_count <= (r_count == CNT_W'(MAX_SITES - 1)) ? '0
                                                                           : r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hnf_checker.sv =====
// Port-level checks for the haversine tracker and their bind to the top level.
// Depends on hnf_pkg.
`default_nettype none
module hnf_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_res_valid,
    input wire logic                  i_res_stall,
    input wire logic [hnf_pkg::NUM_W-1:0]  o_site_number,
    input wire logic [hnf_pkg::DIST_W-1:0] o_site_distance,
    input wire logic [hnf_pkg::DIST_W-1:0] o_nearest_distance,
    input wire logic [hnf_pkg::DIST_W-1:0] o_farthest_distance
);
    import hnf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_site_number)
            && $stable(o_site_distance))
        else $error("stalled result changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_nearest_distance <= o_site_distance
            && o_site_distance <= o_farthest_distance)
        else $error("nearest/farthest bracket broken");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_farthest_distance <= DIST_MAX)
        else $error("distance above saturation");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");
endmodule

bind haversine_nearest_farthest hnf_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/haversine_nearest_farthest_tb.sv =====
// Self-checking testbench for haversine_nearest_farthest: APB register setup,
// site stream with bursty sender and stalling receiver, fixed-point predictor.
// Depends on hnf_pkg and the RTL of haversine_nearest_farthest.
module haversine_nearest_farthest_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_ORIGIN_LAT = 0;
    localparam int REG_ORIGIN_LON = 1;
    localparam int REG_RADIUS     = 2;
    localparam int NSTEPS         = 24;
    localparam longint LAT_LIM    = 90000000;
    localparam longint LON_LIM    = 180000000;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint GAIN_Q30   = 64'h26DD3B6A;
    localparam longint HALF_PI_Q30 = 64'h6487ED51;
    localparam longint UNIT_Q30   = 64'h40000000;
    localparam longint unsigned DIST_SAT = 64'd2573400;
    localparam longint ATAN_TAB [NSTEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    typedef struct {
        logic [hnf_pkg::NUM_W-1:0]  number;
        logic [hnf_pkg::DIST_W-1:0] distance;
        logic                       done;
        logic [hnf_pkg::NUM_W-1:0]  near_num;
        logic [hnf_pkg::DIST_W-1:0] near_dist;
        logic [hnf_pkg::NUM_W-1:0]  far_num;
        logic [hnf_pkg::DIST_W-1:0] far_dist;
    } t_site_result;

    logic i_clk, i_rst_n;
    logic i_site_valid, o_site_stall;
    logic signed [27:0] i_site_latitude;
    logic signed [28:0] i_site_longitude;
    logic i_final_site;
    logic o_res_valid, i_res_stall;
    logic [hnf_pkg::NUM_W-1:0]  o_site_number, o_nearest_number, o_farthest_number;
    logic [hnf_pkg::DIST_W-1:0] o_site_distance, o_nearest_distance, o_farthest_distance;
    logic o_set_done;
    logic psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    haversine_nearest_farthest dut (.*);

    // predictor state
    logic [27:0] org_lat;
    logic [28:0] org_lon;
    logic [12:0] radius_km;
    logic [9:0]  set_count;
    logic [21:0] near_d, far_d;
    logic [9:0]  near_i, far_i;

    t_site_result pending_results[$];
    int errors, sites_sent, results_seen, sets_closed;
    int burst_left;
    logic prev_lat_ok;
    logic signed [27:0] prev_lat;
    logic signed [28:0] prev_lon;

    initial begin
        i_clk = 1'b0;
    end
    always #6 i_clk = ~i_clk;

    function automatic longint clamp_sym(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint clamp_pos(longint v, longint hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned qmul(longint unsigned p, longint unsigned q);
        return (p * q + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = GAIN_Q30;
        y = 0;
        z = ang;
        for (int i = 0; i < NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
            end
        end
        c = clamp_pos(x, UNIT_Q30);
        s = clamp_pos(y, UNIT_Q30);
    endfunction

    function automatic longint arc_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
            end else if (y < 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
            end
        end
        return clamp_pos(z, HALF_PI_Q30);
    endfunction

    function automatic longint unsigned great_circle_dist(longint lat2, longint lon2);
        longint lat1, lon1, c1, c2, slat, slon, unused;
        longint unsigned dlat, dlon, a, sa, sb, ang, d;
        lat1 = clamp_sym(longint'($signed(org_lat)), LAT_LIM);
        lon1 = clamp_sym(longint'($signed(org_lon)), LON_LIM);
        dlat = lat1 > lat2 ? lat1 - lat2 : lat2 - lat1;
        dlon = lon1 > lon2 ? lon1 - lon2 : lon2 - lon1;
        if (dlon > LON_LIM) dlon = 2 * LON_LIM - dlon;
        sin_cos((dlat * PI_Q30 + 180000000) / 360000000, unused, slat);
        sin_cos((dlon * PI_Q30 + 180000000) / 360000000, unused, slon);
        sin_cos(((lat1 < 0 ? -lat1 : lat1) * PI_Q30 + 90000000) / 180000000, c1, unused);
        sin_cos(((lat2 < 0 ? -lat2 : lat2) * PI_Q30 + 90000000) / 180000000, c2, unused);
        a = qmul(slat, slat) + qmul(qmul(c1, c2), qmul(slon, slon));
        if (a > UNIT_Q30) a = UNIT_Q30;
        sa = int_sqrt(a << 30);
        sb = int_sqrt((UNIT_Q30 - a) << 30);
        ang = 2 * arc_angle(sb, sa);
        d = (longint'(radius_km) * 100 * ang + (64'd1 << 29)) >> 30;
        return d > DIST_SAT ? DIST_SAT : d;
    endfunction

    function automatic void clear_tracking();
        set_count = '0;
        near_d = '1;
        near_i = '0;
        far_d = '0;
        far_i = '0;
    endfunction

    function automatic void predict_site(logic [27:0] lat, logic [28:0] lon, logic fin);
        t_site_result r;
        logic [21:0] d;
        d = 22'(great_circle_dist(clamp_sym(longint'($signed(lat)), LAT_LIM),
                                  clamp_sym(longint'($signed(lon)), LON_LIM)));
        if (d < near_d) begin
            near_d = d; near_i = set_count;
        end
        if (d >= far_d) begin
            far_d = d; far_i = set_count;
        end
        r.number = set_count;
        r.distance = d;
        r.done = fin;
        r.near_num = near_i;
        r.near_dist = near_d;
        r.far_num = far_i;
        r.far_dist = far_d;
        pending_results.push_back(r);
        if (fin) clear_tracking();
        else set_count = set_count + 1'b1;
    endfunction

    // caller stands at a rising edge; returns at the edge of the transfer
    task automatic send_site(logic [27:0] lat, logic [28:0] lon, logic fin);
        if (burst_left == 0) begin
            i_site_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_site_valid <= 1'b1;
        i_site_latitude <= lat;
        i_site_longitude <= lon;
        i_final_site <= fin;
        @(posedge i_clk);
        while (o_site_stall) @(posedge i_clk);
        predict_site(lat, lon, fin);
        sites_sent++;
        if (fin) sets_closed++;
        prev_lat = lat;
        prev_lon = lon;
        prev_lat_ok = 1'b1;
    endtask

    task automatic drain();
        i_site_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ORIGIN_LAT: org_lat = value[27:0];
            REG_ORIGIN_LON: org_lon = value[28:0];
            REG_RADIUS:     radius_km = value[12:0];
            default: ;
        endcase
    endtask

    task automatic set_origin(logic [27:0] lat, logic [28:0] lon, logic [12:0] rad);
        write_reg(REG_ORIGIN_LAT, 32'(lat));
        write_reg(REG_ORIGIN_LON, 32'(lon));
        write_reg(REG_RADIUS, 32'(rad));
        @(posedge i_clk);
    endtask

    task automatic send_random_site(logic fin);
        logic [27:0] lat;
        logic [28:0] lon;
        if (prev_lat_ok && $urandom_range(0, 9) == 0) begin
            lat = prev_lat;
            lon = prev_lon;
        end else begin
            if ($urandom_range(0, 7) == 0) lat = 28'($urandom);
            else lat = 28'(int'($urandom_range(0, 180000000)) - 90000000);
            if ($urandom_range(0, 7) == 0) lon = 29'($urandom);
            else lon = 29'(int'($urandom_range(0, 360000000)) - 180000000);
        end
        send_site(lat, lon, fin);
    endtask

    task automatic test_directed_sites();
        send_site(28'sd0, 29'sd0, 1'b0);
        send_site(28'sd0, 29'sd0, 1'b0);
        send_site(28'sd90000000, 29'sd0, 1'b0);
        send_site(-28'sd90000000, 29'sd0, 1'b0);
        send_site(28'sd0, 29'sd180000000, 1'b0);
        send_site(28'sd0, -29'sd180000000, 1'b0);
        send_site(28'sd90000000, 29'sd180000000, 1'b0);
        send_site(-28'sd90000000, -29'sd180000000, 1'b0);
        send_site(28'h7FFFFFF, 29'h0FFFFFFF, 1'b0);
        send_site(28'h8000000, 29'h10000000, 1'b0);
        send_site(28'hFFFFFFF, 29'h1FFFFFFF, 1'b0);
        send_site(28'sd0, 29'sd180000000, 1'b1);
        send_site(28'sd0, 29'sd0, 1'b1);
        drain();
    endtask

    task automatic test_origin_settings();
        logic [27:0] lats [5] = '{28'sd45000000, -28'sd90000000, 28'h7FFFFFF,
                                  28'h8000000, 28'sd90000000};
        logic [28:0] lons [5] = '{29'sd170000000, -29'sd180000000, 29'h0FFFFFFF,
                                  29'h10000000, 29'sd180000000};
        logic [12:0] rads [5] = '{13'd8191, 13'd1, 13'd0, 13'd6371, 13'd4000};
        for (int p = 0; p < 5; p++) begin
            set_origin(lats[p], lons[p], rads[p]);
            send_site(28'sd45000000, -29'sd170000000, 1'b0);
            send_site(-28'sd45000000, 29'sd10000000, 1'b0);
            for (int k = 0; k < 8; k++) send_random_site($urandom_range(0, 5) == 0);
            send_site(28'sd0, 29'sd0, 1'b1);
            drain();
        end
    endtask

    task automatic test_count_wrap();
        set_origin(28'sd0, 29'sd0, 13'd6371);
        for (int k = 0; k < 1030; k++) begin
            if (k == 500) begin
                drain();
                set_origin(28'($urandom_range(0, 90000000)), 29'sd0, 13'd6371);
            end
            send_random_site(k == 1029);
        end
        drain();
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // receiver stall in random runs, with long open stretches
    int stall_run;
    logic stall_on;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_on = ($urandom_range(0, 2) == 0);
            stall_run = $urandom_range(1, 40);
        end
        stall_run--;
        i_res_stall <= stall_on;
    end

    always @(posedge i_clk) begin
        t_site_result e;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("site_number", e.number, o_site_number);
                check_field("site_distance", e.distance, o_site_distance);
                check_field("set_done", e.done, o_set_done);
                check_field("nearest_number", e.near_num, o_nearest_number);
                check_field("nearest_distance", e.near_dist, o_nearest_distance);
                check_field("farthest_number", e.far_num, o_farthest_number);
                check_field("farthest_distance", e.far_dist, o_farthest_distance);
            end
        end
    end

    initial begin
        #30ms;
        $display("haversine_nearest_farthest_tb: FAIL");
        $finish;
    end

    initial begin
        stall_run = 0;
        stall_on = 1'b0;
        errors = 0;
        sites_sent = 0;
        results_seen = 0;
        sets_closed = 0;
        burst_left = 0;
        prev_lat_ok = 1'b0;
        org_lat = '0;
        org_lon = '0;
        radius_km = 13'd6371;
        clear_tracking();
        i_rst_n <= 1'b0;
        i_site_valid <= 1'b0;
        i_site_latitude <= '0;
        i_site_longitude <= '0;
        i_final_site <= 1'b0;
        i_res_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sites();
        test_origin_settings();
        test_count_wrap();
        $display("Sent %0d sites in %0d closed sets, checked %0d results", sites_sent,
                 sets_closed, results_seen);
        $display("covering extremes, out-of-range clamps, ties, zero radius, count wrap");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("haversine_nearest_farthest_tb: PASS");
        end else begin
            $display("haversine_nearest_farthest_tb: FAIL");
        end
        $finish;
    end
endmodule
